// ===== rtl/fpa_pkg.sv =====
// ----------------------------------------------------------------------------
// Fixed-point ALU package
// Command codes and default settings shared by the ALU and its checker.
// ----------------------------------------------------------------------------
`default_nettype none

package fpa_pkg;

  localparam int unsigned FRAC_BITS_DEF = 8;
  localparam int unsigned WORD_W        = 32;
  localparam int unsigned CMD_W         = 4;

  typedef enum logic [CMD_W-1:0] {
    CMD_ADD  = 4'd0,
    CMD_SUB  = 4'd1,
    CMD_MUL  = 4'd2,
    CMD_DIV  = 4'd3,
    CMD_MIN  = 4'd4,
    CMD_MAX  = 4'd5,
    CMD_INC  = 4'd6,
    CMD_DEC  = 4'd7,
    CMD_ITOF = 4'd8,
    CMD_FTOI = 4'd9
  } cmd_t;

  // Compare flags that travel down the pipeline with every beat.
  typedef struct packed {
    logic lt;
    logic eq;
    logic gt;
  } cmp_flags_t;

endpackage

`default_nettype wire

// ===== rtl/fixed_point_alu_unit.sv =====
// ----------------------------------------------------------------------------
// Fixed-point ALU unit
// Signed 32-bit fixed-point ALU, FRAC_BITS fraction bits, fully pipelined.
// ----------------------------------------------------------------------------
// Usage: a command beat is taken at a rising edge where start is high and
// busy is low. Each beat carries a command code and two raw 32-bit operands.
// Exactly one result beat comes back per command, in order, marked by
// out_valid for a single cycle, with the result word, the divide-by-zero
// flag and the three signed compare flags of operand_a against operand_b.
//
// Every command passes through the same stages (FRAC_BITS = 8 gives Q24.8):
// one input register, one setup stage with the multiplier, one restoring divide
// step per quotient bit (32 + FRAC_BITS stages, one compare-subtract each),
// a rounding stage and the output register. Short commands ride along the
// same stages so results stay in order.
//
// Throughput is one command per cycle; busy is high only during reset and in
// the first cycle after it. Reset clears all valid bits, so no result beat
// appears from work in flight. The receiver cannot stall, so nothing ever
// backs up: each result is shown once and then dropped.
// ----------------------------------------------------------------------------
`default_nettype none

module fixed_point_alu_unit #(
  parameter int unsigned FRAC_BITS = fpa_pkg::FRAC_BITS_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                start,
  output logic                     busy,
  input  wire logic [3:0]          in_command,
  input  wire logic signed [31:0]  in_operand_a,
  input  wire logic signed [31:0]  in_operand_b,
  output logic                     out_valid,
  output logic signed [31:0]       out_result,
  output logic                     out_divide_by_zero,
  output logic                     out_a_less_than_b,
  output logic                     out_a_equals_b,
  output logic                     out_a_greater_than_b
);

  // Numerator width of the divider: |a| shifted up by the fraction bits.
  localparam int unsigned DW = 32 + FRAC_BITS;

  logic busy_r;
  logic accept;

  // Input register.
  logic               a_vld_r;
  logic [3:0]         a_cmd_r;
  logic signed [31:0] a_opa_r;
  logic signed [31:0] a_opb_r;

  // Setup stage signals.
  logic [31:0]           simple_nxt;
  fpa_pkg::cmp_flags_t   flg_nxt;
  logic [31:0]           mag_a;
  logic [31:0]           mag_b;
  logic signed [63:0]    prod_r;
  logic signed [63:0]    prod_sh;

  // Divider pipeline, one entry per stage.
  logic [DW:0]           vld_r;
  logic [3:0]            cmd_r [DW+1];
  logic [31:0]           res_r [DW+1];
  fpa_pkg::cmp_flags_t   flg_r [DW+1];
  logic                  dz_r  [DW+1];
  logic                  neg_r [DW+1];
  logic [31:0]           magb_r[DW+1];
  logic [31:0]           rem_r [DW+1];
  logic [DW-1:0]         num_r [DW+1];

  // Rounding stage.
  logic                  rnd_vld_r;
  logic [31:0]           rnd_res_r;
  logic                  rnd_neg_r;
  logic                  rnd_dz_r;
  fpa_pkg::cmp_flags_t   rnd_flg_r;
  logic                  rnd_up;
  logic [31:0]           rnd_res_nxt;
  logic                  is_div_last;

  assign accept = start && !busy_r;
  assign busy   = busy_r;

  always_ff @(posedge clk) begin
    busy_r <= !rst_n;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
    end else begin
      a_vld_r <= accept;
    end
    if (accept) begin
      a_cmd_r <= in_command;
      a_opa_r <= in_operand_a;
      a_opb_r <= in_operand_b;
    end
  end

  // Setup: compares, the short commands, the product and divider operands.
  assign flg_nxt.lt = a_opa_r < a_opb_r;
  assign flg_nxt.eq = a_opa_r == a_opb_r;
  assign flg_nxt.gt = a_opa_r > a_opb_r;
  assign mag_a = a_opa_r[31] ? (32'd0 - a_opa_r) : a_opa_r;
  assign mag_b = a_opb_r[31] ? (32'd0 - a_opb_r) : a_opb_r;

  always_comb begin
    case (a_cmd_r)
      fpa_pkg::CMD_ADD:  simple_nxt = a_opa_r + a_opb_r;
      fpa_pkg::CMD_SUB:  simple_nxt = a_opa_r - a_opb_r;
      fpa_pkg::CMD_MIN:  simple_nxt = flg_nxt.lt ? a_opa_r : a_opb_r;
      fpa_pkg::CMD_MAX:  simple_nxt = flg_nxt.gt ? a_opa_r : a_opb_r;
      fpa_pkg::CMD_INC:  simple_nxt = a_opa_r + 32'sd1;
      fpa_pkg::CMD_DEC:  simple_nxt = a_opa_r - 32'sd1;
      fpa_pkg::CMD_ITOF: simple_nxt = a_opa_r <<< FRAC_BITS;
      fpa_pkg::CMD_FTOI: simple_nxt = a_opa_r >>> FRAC_BITS;
      default:           simple_nxt = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else begin
      vld_r[0] <= a_vld_r;
    end
    cmd_r[0]  <= a_cmd_r;
    res_r[0]  <= simple_nxt;
    flg_r[0]  <= flg_nxt;
    dz_r[0]   <= (a_opb_r == 32'sd0);
    neg_r[0]  <= a_opa_r[31] ^ a_opb_r[31];
    magb_r[0] <= mag_b;
    rem_r[0]  <= 32'd0;
    num_r[0]  <= {mag_a, FRAC_BITS'(0)};
    prod_r    <= 64'(a_opa_r) * 64'(a_opb_r);
  end

  assign prod_sh = prod_r >>> FRAC_BITS;

  // Restoring division, one quotient bit per stage. The quotient bits shift
  // into the low end of the numerator register as its bits are used up.
  for (genvar k = 0; k < DW; k++) begin : g_div
    logic [32:0] trial;
    logic [32:0] diff;
    logic        qbit;

    assign trial = {rem_r[k], num_r[k][DW-1]};
    assign diff  = trial - {1'b0, magb_r[k]};
    assign qbit  = !diff[32];

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k+1] <= 1'b0;
      end else begin
        vld_r[k+1] <= vld_r[k];
      end
      cmd_r[k+1]  <= cmd_r[k];
      flg_r[k+1]  <= flg_r[k];
      dz_r[k+1]   <= dz_r[k];
      neg_r[k+1]  <= neg_r[k];
      magb_r[k+1] <= magb_r[k];
      rem_r[k+1]  <= qbit ? diff[31:0] : trial[31:0];
      num_r[k+1]  <= {num_r[k][DW-2:0], qbit};
      if (k == 0 && cmd_r[k] == fpa_pkg::CMD_MUL) begin
        res_r[k+1] <= prod_sh[31:0];
      end else begin
        res_r[k+1] <= res_r[k];
      end
    end
  end

  // Round half away from zero on the magnitude: up when 2*rem >= |b|.
  assign is_div_last = (cmd_r[DW] == fpa_pkg::CMD_DIV);
  assign rnd_up      = ({rem_r[DW], 1'b0} >= {1'b0, magb_r[DW]});

  always_comb begin
    if (is_div_last && dz_r[DW]) begin
      rnd_res_nxt = 32'd0;
    end else if (is_div_last) begin
      rnd_res_nxt = num_r[DW][31:0] + {31'd0, rnd_up};
    end else begin
      rnd_res_nxt = res_r[DW];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rnd_vld_r <= 1'b0;
    end else begin
      rnd_vld_r <= vld_r[DW];
    end
    rnd_res_r <= rnd_res_nxt;
    rnd_neg_r <= is_div_last && neg_r[DW];
    rnd_dz_r  <= is_div_last && dz_r[DW];
    rnd_flg_r <= flg_r[DW];
  end

  // Output register; the sign of a quotient is applied here.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= rnd_vld_r;
    end
    out_result           <= rnd_neg_r ? (32'd0 - rnd_res_r) : rnd_res_r;
    out_divide_by_zero   <= rnd_dz_r;
    out_a_less_than_b    <= rnd_flg_r.lt;
    out_a_equals_b       <= rnd_flg_r.eq;
    out_a_greater_than_b <= rnd_flg_r.gt;
  end

endmodule

`default_nettype wire

// ===== rtl/fpa_checker.sv =====
// ----------------------------------------------------------------------------
// Fixed-point ALU checker
// Port-level assertions on latency, flags and reset behavior of the ALU.
// ----------------------------------------------------------------------------
`default_nettype none

module fpa_checker #(
  parameter int unsigned FRAC_BITS = fpa_pkg::FRAC_BITS_DEF
) (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        start,
  input wire logic        busy,
  input wire logic        out_valid,
  input wire logic [31:0] out_result,
  input wire logic        out_divide_by_zero,
  input wire logic        out_a_less_than_b,
  input wire logic        out_a_equals_b,
  input wire logic        out_a_greater_than_b
);

  localparam int unsigned LAT = 36 + FRAC_BITS;

  // Every accepted command produces its result a fixed time later.
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##LAT out_valid)
    else $error("result beat missing at fixed latency");

  // Exactly one compare relation holds on each result.
  a_cmp_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $onehot({out_a_less_than_b, out_a_equals_b, out_a_greater_than_b}))
    else $error("compare flags not one-hot");

  // A divide by zero gives a zero result with equal-or-not flags unaffected.
  a_dz_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_divide_by_zero) |-> (out_result == 32'd0))
    else $error("divide by zero with nonzero result");

  // Busy is low once rst_n has been sampled high at this edge and the previous one.
  a_busy_release: assert property (@(posedge clk)
    (rst_n && $past(rst_n)) |-> !busy)
    else $error("busy stuck after reset");

  // No result beat in the first cycle after reset is released.
  a_reset_quiet: assert property (@(posedge clk)
    (rst_n && !$past(rst_n)) |-> !out_valid)
    else $error("result beat right after reset");

endmodule

bind fixed_point_alu_unit fpa_checker #(
  .FRAC_BITS(FRAC_BITS)
) u_fpa_checker (
  .clk                  (clk),
  .rst_n                (rst_n),
  .start                (start),
  .busy                 (busy),
  .out_valid            (out_valid),
  .out_result           (out_result),
  .out_divide_by_zero   (out_divide_by_zero),
  .out_a_less_than_b    (out_a_less_than_b),
  .out_a_equals_b       (out_a_equals_b),
  .out_a_greater_than_b (out_a_greater_than_b)
);

`default_nettype wire

// ===== test/fixed_point_alu_unit_tb.sv =====
// ----------------------------------------------------------------------------
// Fixed-point ALU unit testbench
// Drives directed and random command beats into the ALU, predicts every
// result word and flag, and checks each result beat against the oldest
// prediction in order.
// ----------------------------------------------------------------------------
`default_nettype none

module fixed_point_alu_unit_tb;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned FRAC   = fpa_pkg::FRAC_BITS_DEF;
  localparam int          N_RAND = 1400;
  localparam int          DRAIN  = 36 + FRAC + 20;

  // Lowest and highest command codes that have no operation.
  localparam logic [3:0] CMD_UNUSED_LO = 4'd10;
  localparam logic [3:0] CMD_UNUSED_HI = 4'd15;

  // One result beat: the word and the four flags.
  typedef struct packed {
    logic [31:0] word;
    logic        dz;
    logic        lt;
    logic        eq;
    logic        gt;
  } alu_result_t;

  // One directed row. When has_exp is set, the typed-in value is checked
  // against the predictor too, so both the table and the predictor are held
  // honest.
  typedef struct packed {
    logic [3:0]  cmd;
    logic [31:0] a;
    logic [31:0] b;
    logic        has_exp;
    alu_result_t exp;
  } alu_row_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  logic [3:0]         in_command = '0;
  logic signed [31:0] in_operand_a = '0;
  logic signed [31:0] in_operand_b = '0;
  logic               out_valid;
  logic signed [31:0] out_result;
  logic               out_divide_by_zero;
  logic               out_a_less_than_b;
  logic               out_a_equals_b;
  logic               out_a_greater_than_b;

  alu_result_t pending_results[$];
  int          error_count = 0;

  fixed_point_alu_unit #(.FRAC_BITS(FRAC)) i_dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .start                (start),
    .busy                 (busy),
    .in_command           (in_command),
    .in_operand_a         (in_operand_a),
    .in_operand_b         (in_operand_b),
    .out_valid            (out_valid),
    .out_result           (out_result),
    .out_divide_by_zero   (out_divide_by_zero),
    .out_a_less_than_b    (out_a_less_than_b),
    .out_a_equals_b       (out_a_equals_b),
    .out_a_greater_than_b (out_a_greater_than_b)
  );

  always #5 clk = ~clk;

  // Computes what the ALU returns for one command beat. MUL, DIV, FTOI and
  // compares use 64 bits so the wrap to 32 bits happens only at the end.
  function automatic alu_result_t compute_alu(input logic [3:0] cmd,
                                              input logic [31:0] a_bits,
                                              input logic [31:0] b_bits);
    alu_result_t      r;
    logic signed [63:0] a;
    logic signed [63:0] b;
    logic signed [63:0] prod;
    logic [63:0]      mag_a;
    logic [63:0]      mag_b;
    logic [63:0]      quo;
    a = 64'(signed'(a_bits));
    b = 64'(signed'(b_bits));
    r = '0;
    case (cmd)
      fpa_pkg::CMD_ADD: begin
        r.word = a_bits + b_bits;
      end
      fpa_pkg::CMD_SUB: begin
        r.word = a_bits - b_bits;
      end
      fpa_pkg::CMD_MUL: begin
        prod = a * b;
        r.word = 32'(prod >>> FRAC);
      end
      fpa_pkg::CMD_DIV: begin
        if (b == 0) begin
          r.dz = 1'b1;
        end else begin
          // Round half away from zero on magnitudes, then restore the sign.
          mag_a = (a < 0) ? 64'(-a) : 64'(a);
          mag_b = (b < 0) ? 64'(-b) : 64'(b);
          quo = (2 * (mag_a << FRAC) + mag_b) / (2 * mag_b);
          if ((a < 0) != (b < 0)) quo = -quo;
          r.word = 32'(quo);
        end
      end
      fpa_pkg::CMD_MIN: begin
        r.word = (a < b) ? a_bits : b_bits;
      end
      fpa_pkg::CMD_MAX: begin
        r.word = (a > b) ? a_bits : b_bits;
      end
      fpa_pkg::CMD_INC: begin
        r.word = a_bits + 32'd1;
      end
      fpa_pkg::CMD_DEC: begin
        r.word = a_bits - 32'd1;
      end
      fpa_pkg::CMD_ITOF: begin
        r.word = a_bits << FRAC;
      end
      fpa_pkg::CMD_FTOI: begin
        r.word = 32'(a >>> FRAC);
      end
      default: begin
        r.word = '0;
      end
    endcase
    r.lt = (a < b);
    r.eq = (a == b);
    r.gt = (a > b);
    return r;
  endfunction

  // Random operand: full-range in a third of the picks, otherwise a small
  // magnitude or a value near the extremes so that rounding and wrap are exercised.
  function automatic logic [31:0] pick_operand();
    case ($urandom_range(0, 5))
      0: return 32'($signed($urandom_range(0, 512)) - 256);
      1: return 32'h8000_0000 + $urandom_range(0, 3);
      2: return 32'h7fff_ffff - $urandom_range(0, 3);
      3: return 32'($signed($urandom_range(0, 1 << 16)) - (1 << 15));
      default: return $urandom();
    endcase
  endfunction

  // Presents one beat at the falling edge and holds it until it is taken.
  // Start stays high between back-to-back beats without being lowered.
  task automatic issue_command(input logic [3:0] cmd, input logic [31:0] a,
                               input logic [31:0] b, input bit gaps);
    int idle;
    if (gaps && $urandom_range(0, 3) == 0) begin
      idle = $urandom_range(1, 4);
      start <= 1'b0;
      repeat (idle) @(negedge clk);
    end
    start        <= 1'b1;
    in_command   <= cmd;
    in_operand_a <= a;
    in_operand_b <= b;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_results.push_back(compute_alu(cmd, a, b));
    @(negedge clk);
  endtask

  // Result checker: every strobe is matched with the oldest prediction.
  always @(posedge clk) begin
    alu_result_t got;
    alu_result_t want;
    if (rst_n && out_valid) begin
      got = {out_result, out_divide_by_zero, out_a_less_than_b, out_a_equals_b,
             out_a_greater_than_b};
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result beat, actual %h", $time, got);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        if (got.word !== want.word) begin
          $display("%0t: result expected %h actual %h", $time, want.word, got.word);
          error_count++;
        end
        if (got.dz !== want.dz) begin
          $display("%0t: divide_by_zero expected %b actual %b", $time, want.dz, got.dz);
          error_count++;
        end
        if (got.lt !== want.lt) begin
          $display("%0t: a_less_than_b expected %b actual %b", $time, want.lt, got.lt);
          error_count++;
        end
        if (got.eq !== want.eq) begin
          $display("%0t: a_equals_b expected %b actual %b", $time, want.eq, got.eq);
          error_count++;
        end
        if (got.gt !== want.gt) begin
          $display("%0t: a_greater_than_b expected %b actual %b", $time, want.gt, got.gt);
          error_count++;
        end
      end
    end
  end

  // Directed table: extremes, every command, divide by zero, wrap and the
  // unused command codes. Rows with a typed-in result were worked by hand.
  // Expected flags are listed as dz, lt, eq, gt.
  alu_row_t directed_rows[] = '{
    '{fpa_pkg::CMD_ADD,  32'h7fff_ffff, 32'h0000_0001, 1'b1,
      '{32'h8000_0000, 1'b0, 1'b0, 1'b0, 1'b1}},
    '{fpa_pkg::CMD_SUB,  32'h8000_0000, 32'h0000_0001, 1'b1,
      '{32'h7fff_ffff, 1'b0, 1'b1, 1'b0, 1'b0}},
    '{fpa_pkg::CMD_MUL,  32'h0000_0100, 32'h0000_0100, 1'b1,
      '{32'h0000_0100, 1'b0, 1'b0, 1'b1, 1'b0}},
    '{fpa_pkg::CMD_MUL,  32'h8000_0000, 32'h8000_0000, 1'b0, '0},
    '{fpa_pkg::CMD_MUL,  32'hffff_ffff, 32'h0000_0001, 1'b1,
      '{32'hffff_ffff, 1'b0, 1'b1, 1'b0, 1'b0}},
    '{fpa_pkg::CMD_DIV,  32'h0000_1234, 32'h0000_0000, 1'b1,
      '{32'h0000_0000, 1'b1, 1'b0, 1'b0, 1'b1}},
    '{fpa_pkg::CMD_DIV,  32'h8000_0000, 32'h0000_0000, 1'b1,
      '{32'h0000_0000, 1'b1, 1'b1, 1'b0, 1'b0}},
    '{fpa_pkg::CMD_DIV,  32'h0000_0100, 32'h0000_0200, 1'b1,
      '{32'h0000_0080, 1'b0, 1'b1, 1'b0, 1'b0}},
    '{fpa_pkg::CMD_DIV,  32'h0000_0001, 32'h0000_0200, 1'b1,
      '{32'h0000_0001, 1'b0, 1'b1, 1'b0, 1'b0}},
    '{fpa_pkg::CMD_DIV,  32'hffff_ffff, 32'h0000_0200, 1'b1,
      '{32'hffff_ffff, 1'b0, 1'b1, 1'b0, 1'b0}},
    '{fpa_pkg::CMD_DIV,  32'h8000_0000, 32'hffff_ffff, 1'b0, '0},
    '{fpa_pkg::CMD_DIV,  32'h7fff_ffff, 32'h0000_0001, 1'b0, '0},
    '{fpa_pkg::CMD_MIN,  32'h8000_0000, 32'h7fff_ffff, 1'b1,
      '{32'h8000_0000, 1'b0, 1'b1, 1'b0, 1'b0}},
    '{fpa_pkg::CMD_MAX,  32'h8000_0000, 32'h7fff_ffff, 1'b1,
      '{32'h7fff_ffff, 1'b0, 1'b1, 1'b0, 1'b0}},
    '{fpa_pkg::CMD_MIN,  32'h0000_0005, 32'h0000_0005, 1'b1,
      '{32'h0000_0005, 1'b0, 1'b0, 1'b1, 1'b0}},
    '{fpa_pkg::CMD_INC,  32'h7fff_ffff, 32'h0000_0000, 1'b1,
      '{32'h8000_0000, 1'b0, 1'b0, 1'b0, 1'b1}},
    '{fpa_pkg::CMD_DEC,  32'h8000_0000, 32'h0000_0000, 1'b1,
      '{32'h7fff_ffff, 1'b0, 1'b1, 1'b0, 1'b0}},
    '{fpa_pkg::CMD_ITOF, 32'h0080_0001, 32'h0000_0000, 1'b1,
      '{32'h8000_0100, 1'b0, 1'b0, 1'b0, 1'b1}},
    '{fpa_pkg::CMD_FTOI, 32'h8000_0000, 32'hffff_ffff, 1'b1,
      '{32'hff80_0000, 1'b0, 1'b1, 1'b0, 1'b0}},
    '{fpa_pkg::CMD_FTOI, 32'h7fff_ffff, 32'h0000_0000, 1'b1,
      '{32'h007f_ffff, 1'b0, 1'b0, 1'b0, 1'b1}},
    '{CMD_UNUSED_LO,     32'h1234_5678, 32'h1234_5678, 1'b1,
      '{32'h0000_0000, 1'b0, 1'b0, 1'b1, 1'b0}},
    '{CMD_UNUSED_HI,     32'hffff_ffff, 32'h0000_0000, 1'b1,
      '{32'h0000_0000, 1'b0, 1'b1, 1'b0, 1'b0}}
  };

  initial begin
    alu_result_t model;
    logic [3:0]  cmd;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i]) begin
      if (directed_rows[i].has_exp) begin
        model = compute_alu(directed_rows[i].cmd, directed_rows[i].a, directed_rows[i].b);
        if (model !== directed_rows[i].exp) begin
          $display("%0t: table row %0d expected %h predicted %h", $time, i,
                   directed_rows[i].exp, model);
          error_count++;
        end
      end
      issue_command(directed_rows[i].cmd, directed_rows[i].a, directed_rows[i].b, 1'b1);
    end

    // Random beats; the last fifth runs back to back with no idle cycles.
    // Mostly defined commands, with some unused codes mixed in.
    for (int n = 0; n < N_RAND; n++) begin
      cmd = ($urandom_range(0, 15) == 0)
            ? 4'($urandom_range(int'(CMD_UNUSED_LO), int'(CMD_UNUSED_HI)))
            : 4'($urandom_range(int'(fpa_pkg::CMD_ADD), int'(fpa_pkg::CMD_FTOI)));
      if ($urandom_range(0, 7) == 0) begin
        model.word = pick_operand();
        issue_command(cmd, model.word, model.word, n < N_RAND * 4 / 5);
      end else begin
        issue_command(cmd, pick_operand(), ($urandom_range(0, 15) == 0) ? 32'd0
                      : pick_operand(), n < N_RAND * 4 / 5);
      end
    end
    start <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
    if (error_count == 0) begin
      $display("fixed_point_alu_unit_tb: PASS");
    end else begin
      $display("fixed_point_alu_unit_tb: FAIL");
    end
    $finish;
  end

  // Watchdog well beyond the slowest correct run.
  initial begin
    #2ms;
    $display("fixed_point_alu_unit_tb: FAIL");
    $finish;
  end

endmodule

`default_nettype wire
